@@ sv/edfrq_pkg.sv @@
package edfrq_pkg;

  localparam int unsigned IdW = 8;
  localparam int unsigned DlW = 32;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SWAP   = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_CHECK  = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_EMPTY     = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_e;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [DlW-1:0] dl;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e       op;
    logic           pop;   // remove the head instead of matching by id
    logic [IdW-1:0] id;
    logic [DlW-1:0] dl;
  } cell_cmd_t;

endpackage

@@ sv/edf_ready_queue_top.sv @@
// EDF ready queue: deadline-sorted row of cells plus one running task.
// Add runs a lookup/remove pass, then an insert pass, before its result; one dropped on
// a full queue skips the insert. Swap with reinsert also runs both; every other item runs the first only.
// One item at a time, each taking the remove and, where needed, the insert pass
// through the cell row. Stalls only while the output register is occupied.
// Reset: queue empty, nothing running; queue cell contents are not cleared.
module edf_ready_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  task_id_i,
  input  logic [30:0] creation_time_i,
  input  logic [30:0] period_i,
  input  logic        running_finished_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        run_valid_o,
  output logic [7:0]  run_id_o,
  output logic        preempt_o,
  output logic [4:0]  ready_count_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            run_flag_q, run_flag_d;
  logic [7:0]      run_task_q, run_task_d;
  logic [31:0]     run_dl_q, run_dl_d;

  logic [1:0]  req_q, req_d;
  logic [7:0]  id_q, id_d;
  logic [31:0] dl_q, dl_d;
  logic        fin_q, fin_d;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic        run_valid_q;
  logic [7:0]  run_id_q;
  logic        preempt_q;
  logic [4:0]  ready_count_q;

  logic        load;
  logic [1:0]  status_n;
  logic        preempt_n;
  logic        out_free;
  logic        full;
  logic        found;
  logic [31:0] count_ext;

  edfrq_pkg::cell_cmd_t cmd;
  edfrq_pkg::entry_t    head;

  edfrq_chain #(
    .Depth (QUEUE_DEPTH),
    .CntW  (CntW)
  ) u_chain (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .count_i (count_q),
    .head_o  (head),
    .found_o (found)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    run_flag_d = run_flag_q;
    run_task_d = run_task_q;
    run_dl_d   = run_dl_q;
    req_d      = req_q;
    id_d       = id_q;
    dl_d       = dl_q;
    fin_d      = fin_q;
    cmd.op     = edfrq_pkg::CELL_HOLD;
    cmd.pop    = (req_q == edfrq_pkg::REQ_SWAP);
    cmd.id     = id_q;
    cmd.dl     = dl_q;
    load       = 1'b0;
    status_n   = edfrq_pkg::STS_OK;
    preempt_n  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          id_d    = task_id_i;
          dl_d    = {1'b0, creation_time_i} + {1'b0, period_i};
          fin_d   = running_finished_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          case (req_q)
            edfrq_pkg::REQ_ADD: begin
              if (!found && full) begin
                status_n = edfrq_pkg::STS_FULL;
                load     = 1'b1;
              end else begin
                cmd.op = edfrq_pkg::CELL_REMOVE;
                if (found) count_d = count_q - CntW'(1);
                if (run_flag_q && run_task_q == id_q) begin
                  run_flag_d = 1'b0;
                  run_task_d = '0;
                  run_dl_d   = '0;
                end
                state_d = ST_INS;
              end
            end
            edfrq_pkg::REQ_SWAP: begin
              if (count_q == '0) begin
                status_n = edfrq_pkg::STS_EMPTY;
                load     = 1'b1;
              end else if (run_flag_q && !fin_q && run_dl_q < head.dl) begin
                load = 1'b1;
              end else begin
                cmd.op     = edfrq_pkg::CELL_REMOVE;
                count_d    = count_q - CntW'(1);
                run_flag_d = 1'b1;
                run_task_d = head.id;
                run_dl_d   = head.dl;
                if (run_flag_q && !fin_q) begin
                  // old running task goes back in sorted order
                  id_d    = run_task_q;
                  dl_d    = run_dl_q;
                  state_d = ST_INS;
                end else begin
                  load = 1'b1;
                end
              end
            end
            edfrq_pkg::REQ_REMOVE: begin
              if (found) begin
                cmd.op  = edfrq_pkg::CELL_REMOVE;
                count_d = count_q - CntW'(1);
              end else begin
                status_n = edfrq_pkg::STS_NOT_FOUND;
              end
              load = 1'b1;
            end
            default: begin
              preempt_n = (count_q != '0) && run_flag_q && (head.dl < run_dl_q);
              load      = 1'b1;
            end
          endcase
        end
      end
      ST_INS: begin
        if (out_free) begin
          cmd.op  = edfrq_pkg::CELL_INSERT;
          count_d = count_q + CntW'(1);
          load    = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load) state_d = ST_IDLE;
  end

  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      run_flag_q  <= 1'b0;
      run_task_q  <= '0;
      run_dl_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      run_flag_q <= run_flag_d;
      run_task_q <= run_task_d;
      run_dl_q   <= run_dl_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    id_q  <= id_d;
    dl_q  <= dl_d;
    fin_q <= fin_d;
    if (load) begin
      status_q      <= status_n;
      run_valid_q   <= run_flag_d;
      run_id_q      <= run_flag_d ? run_task_d : 8'd0;
      preempt_q     <= preempt_n;
      ready_count_q <= count_ext[4:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign run_valid_o   = run_valid_q;
  assign run_id_o      = run_id_q;
  assign preempt_o     = preempt_q;
  assign ready_count_o = ready_count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("ready count above queue depth");

  a_ins_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INS |-> !full)
    else $error("insert pass with a full queue");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_EXEC)
    else $error("accepted item did not start");

  a_no_result_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result loaded over one not yet taken");

  a_pop_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && req_q == edfrq_pkg::REQ_SWAP && out_free && count_q != '0)
    |=> run_flag_q)
    else $error("swap left nothing running");

endmodule

@@ sv/edfrq_cell.sv @@
module edfrq_cell (
  input  logic                  clk_i,
  input  edfrq_pkg::cell_cmd_t  cmd_i,
  input  logic                  first_i,
  input  logic                  valid_i,
  input  edfrq_pkg::entry_t     left_i,
  input  logic                  left_later_i,
  input  logic                  left_hit_i,
  input  edfrq_pkg::entry_t     right_i,
  output edfrq_pkg::entry_t     entry_o,
  output logic                  later_o,
  output logic                  hit_o
);

  edfrq_pkg::entry_t entry_q, entry_d;
  edfrq_pkg::entry_t new_ent;
  logic              hit_here;

  assign new_ent.id = cmd_i.id;
  assign new_ent.dl = cmd_i.dl;

  // entry goes after the new item only if its deadline is strictly later
  assign later_o  = !valid_i || (entry_q.dl > cmd_i.dl);
  assign hit_here = valid_i && (cmd_i.pop ? first_i : (entry_q.id == cmd_i.id));
  assign hit_o    = left_hit_i || hit_here;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      edfrq_pkg::CELL_REMOVE: begin
        if (hit_o) entry_d = right_i;
      end
      edfrq_pkg::CELL_INSERT: begin
        if (later_o) entry_d = left_later_i ? left_i : new_ent;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ sv/edfrq_chain.sv @@
module edfrq_chain #(
  parameter int unsigned Depth = 16,
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                  clk_i,
  input  edfrq_pkg::cell_cmd_t  cmd_i,
  input  logic [CntW-1:0]       count_i,
  output edfrq_pkg::entry_t     head_o,
  output logic                  found_o
);

  edfrq_pkg::entry_t ent   [Depth];
  logic              later [Depth];
  logic              hit   [Depth];
  edfrq_pkg::entry_t new_ent;

  assign new_ent.id = cmd_i.id;
  assign new_ent.dl = cmd_i.dl;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    edfrq_pkg::entry_t left, right;
    logic              left_later, left_hit;

    if (i == 0) begin : g_first
      assign left       = new_ent;
      assign left_later = 1'b1;
      assign left_hit   = 1'b0;
    end else begin : g_mid
      assign left       = ent[i-1];
      assign left_later = later[i-1];
      assign left_hit   = hit[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = ent[i+1];
    end

    edfrq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd_i),
      .first_i      (i == 0),
      .valid_i      (CntW'(i) < count_i),
      .left_i       (left),
      .left_later_i (left_later),
      .left_hit_i   (left_hit),
      .right_i      (right),
      .entry_o      (ent[i]),
      .later_o      (later[i]),
      .hit_o        (hit[i])
    );
  end

  assign head_o  = ent[0];
  assign found_o = hit[Depth-1];

endmodule

@@ bench/tb_edf_ready_queue_top.sv @@
module tb_edf_ready_queue_top;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 27;

  typedef struct packed {
    logic [1:0] status;
    logic       run_valid;
    logic [7:0] run_id;
    logic       preempt;
    logic [4:0] ready_count;
  } sched_result_t;

  bit          clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [7:0]  task_id_i;
  logic [30:0] creation_time_i;
  logic [30:0] period_i;
  logic        running_finished_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        run_valid_o;
  logic [7:0]  run_id_o;
  logic        preempt_o;
  logic [4:0]  ready_count_o;

  // scheduler state as predicted
  logic [7:0]  ready_ids [QDEPTH];
  logic [31:0] ready_dls [QDEPTH];
  int          ready_len = 0;
  logic        run_on = 1'b0;
  logic [7:0]  run_tid = '0;
  logic [31:0] run_dl = '0;

  sched_result_t pending_results[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            stall_en = 1'b1;

  edf_ready_queue_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .task_id_i          (task_id_i),
    .creation_time_i    (creation_time_i),
    .period_i           (period_i),
    .running_finished_i (running_finished_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .run_valid_o        (run_valid_o),
    .run_id_o           (run_id_o),
    .preempt_o          (preempt_o),
    .ready_count_o      (ready_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("edf_ready_queue_top: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= stall_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // ---------------- predictor ----------------

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < ready_len; i++) begin
      ready_ids[i] = ready_ids[i+1];
      ready_dls[i] = ready_dls[i+1];
    end
    ready_len--;
  endfunction

  // equal deadlines keep arrival order
  function automatic void insert_by_deadline(logic [7:0] id, logic [31:0] dl);
    int pos;
    pos = 0;
    while (pos < ready_len && !(dl < ready_dls[pos])) pos++;
    for (int i = ready_len; i > pos; i--) begin
      ready_ids[i] = ready_ids[i-1];
      ready_dls[i] = ready_dls[i-1];
    end
    ready_ids[pos] = id;
    ready_dls[pos] = dl;
    ready_len++;
  endfunction

  function automatic int find_ready(logic [7:0] id);
    for (int i = 0; i < ready_len; i++) begin
      if (ready_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic sched_result_t apply_request(logic [1:0] req, logic [7:0] id,
                                                  logic [30:0] ct, logic [30:0] per,
                                                  logic fin);
    sched_result_t r;
    int            pos;
    logic          reinsert;
    logic [7:0]    old_id;
    logic [31:0]   old_dl;
    r = '0;
    r.status = edfrq_pkg::STS_OK;
    case (req)
      edfrq_pkg::REQ_ADD: begin
        pos = find_ready(id);
        if (pos < 0 && ready_len >= QDEPTH) begin
          r.status = edfrq_pkg::STS_FULL;
        end else begin
          if (pos >= 0) drop_entry(pos);
          if (run_on && run_tid == id) begin
            run_on  = 1'b0;
            run_tid = '0;
            run_dl  = '0;
          end
          insert_by_deadline(id, {1'b0, ct} + {1'b0, per});
        end
      end
      edfrq_pkg::REQ_SWAP: begin
        if (ready_len == 0) begin
          r.status = edfrq_pkg::STS_EMPTY;
        end else if (!(run_on && !fin && run_dl < ready_dls[0])) begin
          // a strictly earlier running task just keeps running
          reinsert = run_on && !fin;
          old_id   = run_tid;
          old_dl   = run_dl;
          run_tid  = ready_ids[0];
          run_dl   = ready_dls[0];
          run_on   = 1'b1;
          drop_entry(0);
          if (reinsert) insert_by_deadline(old_id, old_dl);
        end
      end
      edfrq_pkg::REQ_REMOVE: begin
        pos = find_ready(id);
        if (pos < 0) r.status = edfrq_pkg::STS_NOT_FOUND;
        else drop_entry(pos);
      end
      edfrq_pkg::REQ_CHECK: begin
        r.preempt = (ready_len > 0) && run_on && (ready_dls[0] < run_dl);
      end
      default: ;
    endcase
    r.run_valid   = run_on;
    r.run_id      = run_on ? run_tid : 8'd0;
    r.ready_count = 5'(ready_len);
    return r;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < 40) begin
      $display("error on %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    end
    error_count++;
  endtask

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", int'(status_o), int'(want.status));
        if (run_valid_o !== want.run_valid)
          report_mismatch("run_valid", int'(run_valid_o), int'(want.run_valid));
        if (run_id_o !== want.run_id)
          report_mismatch("run_id", int'(run_id_o), int'(want.run_id));
        if (preempt_o !== want.preempt)
          report_mismatch("preempt", int'(preempt_o), int'(want.preempt));
        if (ready_count_o !== want.ready_count)
          report_mismatch("ready_count", int'(ready_count_o), int'(want.ready_count));
      end
    end
  end

  // ---------------- driving ----------------

  // called and returns at a falling edge; valid is left high for a following item
  task automatic send_item(logic [1:0] req, logic [7:0] id, logic [30:0] ct,
                           logic [30:0] per, logic fin);
    if (stall_en) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i         <= 1'b1;
    req_type_i         <= req;
    task_id_i          <= id;
    creation_time_i    <= ct;
    period_i           <= per;
    running_finished_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_request(req, id, ct, per, fin));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 99) < 80) return 8'($urandom_range(0, 19));
    return 8'($urandom_range(0, 255));
  endfunction

  // small values collide on deadline, large ones sweep every bit
  function automatic logic [30:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 31'($urandom_range(0, 15));
    if (r < 45) return 31'h7FFF_FFFF;
    return 31'($urandom());
  endfunction

  // ---------------- tests ----------------

  task automatic test_corner_cases();
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b0);       // empty queue
    send_item(edfrq_pkg::REQ_CHECK, 8'd0, '0, '0, 1'b0);      // nothing at all
    send_item(edfrq_pkg::REQ_REMOVE, 8'd0, '0, '0, 1'b0);     // not found
    send_item(edfrq_pkg::REQ_ADD, 8'd255, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b0);       // nothing running yet
    send_item(edfrq_pkg::REQ_CHECK, 8'd0, '0, '0, 1'b0);      // empty queue
    send_item(edfrq_pkg::REQ_ADD, 8'd0, '0, '0, 1'b0);
    send_item(edfrq_pkg::REQ_ADD, 8'd170, '0, '0, 1'b0);      // same deadline
    send_item(edfrq_pkg::REQ_CHECK, 8'd0, '0, '0, 1'b1);      // head earlier
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b0);       // reinsert running
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b0);       // tie goes behind
    // running id
    send_item(edfrq_pkg::REQ_ADD, 8'd170, 31'h5555_5555, 31'h2AAA_AAAA, 1'b0);
    send_item(edfrq_pkg::REQ_ADD, 8'd255, 31'd1, 31'd2, 1'b0); // already queued
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b1);
    send_item(edfrq_pkg::REQ_ADD, 8'd85, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0);
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b0);       // running stays
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b1);       // finished dropped
    send_item(edfrq_pkg::REQ_REMOVE, 8'd85, '0, '0, 1'b0);
    send_item(edfrq_pkg::REQ_REMOVE, 8'd255, '0, '0, 1'b0);   // running, not queued
  endtask

  task automatic test_full_queue();
    logic [7:0] fresh;
    fresh = 8'd100;
    while (ready_len < QDEPTH) begin
      send_item(edfrq_pkg::REQ_ADD, fresh, pick_time(), pick_time(), 1'b0);
      fresh++;
    end
    send_item(edfrq_pkg::REQ_ADD, 8'd200, '0, '0, 1'b0);      // full, new id
    send_item(edfrq_pkg::REQ_ADD, run_tid, '0, '0, 1'b0);     // full, running kept
    send_item(edfrq_pkg::REQ_ADD, 8'd100, '0, '0, 1'b0);      // full, requeue ok
    send_item(edfrq_pkg::REQ_CHECK, 8'd0, '0, '0, 1'b0);
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b0);       // reinsert while full
    send_item(edfrq_pkg::REQ_SWAP, 8'd0, '0, '0, 1'b1);
  endtask

  task automatic test_random_traffic(int n, int add_pct);
    int         sel;
    int         rest;
    logic [1:0] req;
    rest = 100 - add_pct;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < add_pct) req = edfrq_pkg::REQ_ADD;
      else if (sel < add_pct + rest * 2 / 5) req = edfrq_pkg::REQ_SWAP;
      else if (sel < add_pct + rest * 7 / 10) req = edfrq_pkg::REQ_REMOVE;
      else req = edfrq_pkg::REQ_CHECK;
      send_item(req, pick_id(), pick_time(), pick_time(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_pause_until_idle();
    for (int k = 0; k < 5; k++) begin
      test_random_traffic(10, 40);
      wait_drained();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    req_type_i         = edfrq_pkg::REQ_ADD;
    task_id_i          = '0;
    creation_time_i    = '0;
    period_i           = '0;
    running_finished_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corner_cases();
    test_full_queue();
    stall_en = 1'b1;
    test_random_traffic(500, 45);
    test_pause_until_idle();
    stall_en = 1'b0;
    test_random_traffic(350, 60);
    stall_en = 1'b1;
    test_random_traffic(300, 30);
    test_random_traffic(250, 50);

    wait_drained();
    if (error_count == 0) begin
      $display("edf_ready_queue_top: match");
    end else begin
      $display("edf_ready_queue_top: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/edfrq_pkg.sv
sv/edfrq_cell.sv
sv/edfrq_chain.sv
sv/edf_ready_queue_top.sv
bench/tb_edf_ready_queue_top.sv
